// ----- rtl/tpefb_pkg.sv -----
// shared constants, types and helpers of the two-plane e-paper frame buffer
`default_nettype none

package tpefb_pkg;

    localparam int PIXEL_WIDTH  = 200;
    localparam int PIXEL_HEIGHT = 200;
    localparam int BYTE_WIDTH   = (PIXEL_WIDTH + 7) / 8;
    localparam int BUF_LEN      = BYTE_WIDTH * PIXEL_HEIGHT;
    localparam int MEM_AW       = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;

    localparam logic [1:0] COLOR_BLACK = 2'd1;
    localparam logic [1:0] COLOR_RED   = 2'd2;

    typedef enum logic [1:0] {
        REQ_PIXEL    = 2'd0,
        REQ_BITMAP   = 2'd1,
        REQ_RD_BLACK = 2'd2,
        REQ_RD_RED   = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        OUT_WRITE,
        OUT_ERROR,
        OUT_RED,
        OUT_BLK_HI,
        OUT_BLK_LO
    } t_out_sel;

    typedef struct packed {
        logic     in_ready;
        logic     clear_wr;
        logic     mem_rd;
        logic     mem_wr;
        logic     byte_sel;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic is_write;
        logic is_black;
        logic range_err;
        logic need_second;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] double_nibble(input logic [3:0] nib);
        logic [7:0] r;
        r = '0;
        for (int b = 0; b < 4; b++) begin
            r[2*b +: 2] = {2{nib[b]}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tpefb_if.sv -----
// request and response channel interfaces of the frame buffer
`default_nettype none

interface tpefb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [1:0]  pixel_color;
    logic [7:0]  pattern;
    logic [3:0]  valid_bits;
    logic [12:0] byte_index;

    modport source (output valid, req_type, pos_x, pos_y, pixel_color, pattern,
                    valid_bits, byte_index, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, pixel_color, pattern,
                    valid_bits, byte_index, output ready);
endinterface

interface tpefb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;
    logic       range_error;

    modport source (output valid, data_byte, is_last, range_error, input ready);
    modport sink   (input valid, data_byte, is_last, range_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/tpefb_ctrl.sv -----
// sequencing state machine of the frame buffer
`default_nettype none

module tpefb_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  tpefb_pkg::t_sts  i_sts,
    output tpefb_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_WR0,
        S_RD1,
        S_WR1,
        S_RESP,
        S_RESP_LO
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.out_sel = tpefb_pkg::OUT_WRITE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) n_state = S_RD0;
            end
            S_RD0: begin
                if (i_sts.range_err) begin
                    n_state = S_RESP;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state = i_sts.is_write ? S_WR0 : S_RESP;
                end
            end
            S_WR0: begin
                o_cmd.mem_wr = 1'b1;
                n_state = i_sts.need_second ? S_RD1 : S_RESP;
            end
            S_RD1: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.byte_sel = 1'b1;
                n_state = S_WR1;
            end
            S_WR1: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.byte_sel = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.range_err)      o_cmd.out_sel = tpefb_pkg::OUT_ERROR;
                else if (i_sts.is_write)  o_cmd.out_sel = tpefb_pkg::OUT_WRITE;
                else if (i_sts.is_black)  o_cmd.out_sel = tpefb_pkg::OUT_BLK_HI;
                else                      o_cmd.out_sel = tpefb_pkg::OUT_RED;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = (i_sts.is_black && !i_sts.range_err) ? S_RESP_LO : S_IDLE;
                end
            end
            S_RESP_LO: begin
                o_cmd.out_sel = tpefb_pkg::OUT_BLK_LO;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tpefb_datapath.sv -----
// request registers, plane memories, read-modify-write logic and result register
`default_nettype none

module tpefb_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  tpefb_pkg::t_cmd  i_cmd,
    output tpefb_pkg::t_sts  o_sts,
    tpefb_req_if.sink        i_req,
    tpefb_rsp_if.source      o_rsp
);

    localparam int AW = tpefb_pkg::MEM_AW;

    // latched request
    tpefb_pkg::t_req_type r_req_type;
    logic [7:0]           r_x;
    logic [7:0]           r_y;
    logic [1:0]           r_color;
    logic [7:0]           r_pat;
    logic [3:0]           r_nbits;
    logic [12:0]          r_idx;

    logic [AW-1:0] r_clr_cnt;

    logic [7:0] r_blk_mem [tpefb_pkg::BUF_LEN];
    logic [7:0] r_red_mem [tpefb_pkg::BUF_LEN];
    logic [7:0] r_blk_rd;
    logic [7:0] r_red_rd;

    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;
    logic       r_out_err;

    logic          load;
    logic          is_write;
    logic [3:0]    nsat;
    logic [3:0]    span;
    logic [7:0]    draw8;
    logic [15:0]   window;
    logic [7:0]    mask;
    logic [8:0]    col_end;
    logic          err_w;
    logic          err_r;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    blk_new;
    logic [7:0]    red_new;
    logic [7:0]    blk_wd;
    logic [7:0]    red_wd;
    logic [7:0]    out_data;
    logic          out_free;

    assign i_req.ready = i_cmd.in_ready;
    assign load        = i_req.valid && i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req_type <= tpefb_pkg::t_req_type'(i_req.req_type);
            r_x        <= i_req.pos_x;
            r_y        <= i_req.pos_y;
            r_color    <= i_req.pixel_color;
            r_pat      <= i_req.pattern;
            r_nbits    <= i_req.valid_bits;
            r_idx      <= i_req.byte_index;
        end
    end

    // a pixel write is a bitmap of one set leading bit
    assign is_write = (r_req_type == tpefb_pkg::REQ_PIXEL) ||
                      (r_req_type == tpefb_pkg::REQ_BITMAP);
    assign nsat     = (r_nbits > 4'd8) ? 4'd8 : r_nbits;
    assign span     = (r_req_type == tpefb_pkg::REQ_PIXEL) ? 4'd1 :
                      ((nsat == 4'd0) ? 4'd1 : nsat);
    assign draw8    = (r_req_type == tpefb_pkg::REQ_PIXEL) ? 8'h80 :
                      (r_pat & ~(8'hFF >> nsat));
    assign window   = {draw8, 8'h00} >> r_x[2:0];
    assign mask     = i_cmd.byte_sel ? window[7:0] : window[15:8];

    assign col_end  = 9'(r_x) + 9'(span) - 9'd1;
    assign err_w    = (9'(r_y) >= 9'(tpefb_pkg::PIXEL_HEIGHT)) ||
                      (col_end >= 9'(tpefb_pkg::PIXEL_WIDTH));
    assign err_r    = (14'(r_idx) >= 14'(tpefb_pkg::BUF_LEN));

    assign base_addr = AW'(r_y) * AW'(tpefb_pkg::BYTE_WIDTH) + AW'(r_x[7:3]);

    always_comb begin
        if (i_cmd.clear_wr)  mem_addr = r_clr_cnt;
        else if (is_write)   mem_addr = base_addr + AW'(i_cmd.byte_sel);
        else                 mem_addr = r_idx[AW-1:0];
    end

    // whiten the masked pixels, then ink the plane that the color names
    assign blk_new = (r_blk_rd | mask) & ~((r_color == tpefb_pkg::COLOR_BLACK) ? mask : 8'h00);
    assign red_new = (r_red_rd | mask) & ~((r_color == tpefb_pkg::COLOR_RED) ? mask : 8'h00);
    assign blk_wd  = i_cmd.clear_wr ? 8'hFF : blk_new;
    assign red_wd  = i_cmd.clear_wr ? 8'hFF : red_new;
    assign mem_we  = i_cmd.clear_wr || i_cmd.mem_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_blk_mem[mem_addr] <= blk_wd;
        if (i_cmd.mem_rd) r_blk_rd <= r_blk_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_red_mem[mem_addr] <= red_wd;
        if (i_cmd.mem_rd) r_red_rd <= r_red_mem[mem_addr];
    end

    // result register
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        case (i_cmd.out_sel)
            tpefb_pkg::OUT_RED:    out_data = r_red_rd;
            tpefb_pkg::OUT_BLK_HI: out_data = tpefb_pkg::double_nibble(r_blk_rd[7:4]);
            tpefb_pkg::OUT_BLK_LO: out_data = tpefb_pkg::double_nibble(r_blk_rd[3:0]);
            default:               out_data = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= out_data;
            r_out_last <= (i_cmd.out_sel != tpefb_pkg::OUT_BLK_HI);
            r_out_err  <= (i_cmd.out_sel == tpefb_pkg::OUT_ERROR);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.data_byte   = r_out_data;
    assign o_rsp.is_last     = r_out_last;
    assign o_rsp.range_error = r_out_err;

    assign o_sts.in_valid    = i_req.valid;
    assign o_sts.clr_last    = (r_clr_cnt == AW'(tpefb_pkg::BUF_LEN - 1));
    assign o_sts.is_write    = is_write;
    assign o_sts.is_black    = (r_req_type == tpefb_pkg::REQ_RD_BLACK);
    assign o_sts.range_err   = is_write ? err_w : err_r;
    assign o_sts.need_second = |window[7:0];
    assign o_sts.out_free    = out_free;

endmodule

`default_nettype wire

// ----- rtl/two_plane_epaper_frame_buffer.sv -----
// top level of the two-plane e-paper frame buffer
//
// two one-bit-per-pixel planes (black and red), msb is the leftmost pixel
// request channel i_req: pixel write, bitmap byte write, black read, red read
// response channel o_rsp: data_byte, is_last, range_error per result
// a write gives one result with data 0; a red read one raw byte; a black
// read two bytes (high nibble doubled, then low nibble doubled)
// out-of-range requests give a single result with range_error set and
// leave both planes untouched
// sequencing: one item at a time, each taken in S_IDLE; a read or an
// out-of-range request passes S_RD0 and S_RESP, a write touching one plane
// byte S_RD0, S_WR0 and S_RESP, a write that straddles two bytes S_RD0,
// S_WR0, S_RD1, S_WR1 and S_RESP; the result register loads in S_RESP and
// a black read loads its second result in S_RESP_LO; each plane byte costs
// a read and a write on the single port of each plane memory
// reset: both planes are swept to 0xff (white), one byte per cycle, over all
// BUF_LEN bytes (5000 at 200x200); i_req.ready stays low during the sweep
// stall: results wait in the output register; the next request is taken
// while a result waits, and processing holds before loading a new result
`default_nettype none

module two_plane_epaper_frame_buffer (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tpefb_req_if.sink    i_req,
    tpefb_rsp_if.source  o_rsp
);

    tpefb_pkg::t_cmd cmd;
    tpefb_pkg::t_sts sts;

    // state machine: sequences clear sweep, read-modify-write and results
    tpefb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: request latch, plane memories, result register
    tpefb_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    // no request transfer while the clear sweep is running
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_wr |-> !i_req.ready)
        else $error("request accepted during clear sweep");

    // a new result never overwrites one the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result register overwritten while stalled");

    // single port plane memories: no read and write in one cycle
    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mem_rd && (cmd.mem_wr || cmd.clear_wr)))
        else $error("plane memory read and write collide");

    // an error result is always a lone zero result
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.range_error) |-> (o_rsp.is_last && o_rsp.data_byte == 8'h00))
        else $error("malformed error result");

endmodule

`default_nettype wire

// ----- tb/sv/two_plane_epaper_frame_buffer_tb.sv -----
// self-checking testbench of the two-plane e-paper frame buffer: directed rows, then random traffic
module two_plane_epaper_frame_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // the reset sweep alone keeps i_req.ready low until every plane byte is white
    localparam int STALL_LIMIT  = 4 * tpefb_pkg::BUF_LEN + 2000;
    localparam int RANDOM_ITEMS = 290;      // per idling phase, four phases
    localparam int DRAIN_CYCLES = 16;

    // one request as offered on the bus; known_cnt > 0 marks a row whose
    // results are typed in instead of predicted
    typedef struct {
        tpefb_pkg::t_req_type kind;
        logic [7:0]           pos_x;
        logic [7:0]           pos_y;
        logic [1:0]           color;
        logic [7:0]           pattern;
        logic [3:0]           nbits;
        logic [12:0]          index;
        int                   known_cnt;
        logic [7:0]           known_d0;
        logic [7:0]           known_d1;
        logic                 known_err;
    } t_fb_request;

    typedef struct {
        logic [7:0] data_byte;
        logic       is_last;
        logic       range_error;
    } t_fb_result;

    logic i_clk;
    logic i_rst_n;

    tpefb_req_if req_bus ();
    tpefb_rsp_if rsp_bus ();

    two_plane_epaper_frame_buffer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // shadow copies of both planes, white after reset
    logic [7:0]  shadow_black [tpefb_pkg::BUF_LEN];
    logic [7:0]  shadow_red   [tpefb_pkg::BUF_LEN];

    t_fb_request offered_q [$];         // presented on the bus, not yet transferred
    t_fb_result  expected_results [$];  // results still owed by the block
    t_fb_request directed_rows [$];
    int          recent_bytes [$];      // plane bytes lately written, read back often

    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void queue_result(input logic [7:0] data, input logic last,
                                         input logic err);
        t_fb_result res;
        res.data_byte   = data;
        res.is_last     = last;
        res.range_error = err;
        expected_results.push_back(res);
    endfunction

    // each nibble bit shows up twice, side by side
    function automatic logic [7:0] spread_nibble(input logic [3:0] n);
        return {{2{n[3]}}, {2{n[2]}}, {2{n[1]}}, {2{n[0]}}};
    endfunction

    // whiten the pixel in both planes, then ink it in the plane of its color
    function automatic void paint_pixel(input int x, input int y, input logic [1:0] color);
        int         addr;
        logic [7:0] mask;
        addr = y * tpefb_pkg::BYTE_WIDTH + x / 8;
        mask = 8'h80 >> (x % 8);
        shadow_black[addr] = shadow_black[addr] | mask;
        shadow_red[addr]   = shadow_red[addr] | mask;
        if (color == tpefb_pkg::COLOR_BLACK) begin
            shadow_black[addr] = shadow_black[addr] & ~mask;
        end else if (color == tpefb_pkg::COLOR_RED) begin
            shadow_red[addr] = shadow_red[addr] & ~mask;
        end
    endfunction

    // updates the shadow planes and queues the results of one transfer
    function automatic void predict_request(input t_fb_request r);
        int         drawn;
        int         span;
        logic [7:0] v;
        case (r.kind)
            tpefb_pkg::REQ_PIXEL: begin
                if (r.pos_x >= tpefb_pkg::PIXEL_WIDTH ||
                    r.pos_y >= tpefb_pkg::PIXEL_HEIGHT) begin
                    queue_result(8'h00, 1'b1, 1'b1);
                end else begin
                    paint_pixel(int'(r.pos_x), int'(r.pos_y), r.color);
                    queue_result(8'h00, 1'b1, 1'b0);
                end
            end
            tpefb_pkg::REQ_BITMAP: begin
                // count saturates at eight; an empty span still checks one column
                drawn = (r.nbits > 8) ? 8 : int'(r.nbits);
                span  = (drawn == 0) ? 1 : drawn;
                if (r.pos_y >= tpefb_pkg::PIXEL_HEIGHT ||
                    int'(r.pos_x) + span - 1 >= tpefb_pkg::PIXEL_WIDTH) begin
                    queue_result(8'h00, 1'b1, 1'b1);
                end else begin
                    for (int i = 0; i < drawn; i++) begin
                        if (r.pattern[7-i]) begin
                            paint_pixel(int'(r.pos_x) + i, int'(r.pos_y), r.color);
                        end
                    end
                    queue_result(8'h00, 1'b1, 1'b0);
                end
            end
            default: begin
                if (r.index >= tpefb_pkg::BUF_LEN) begin
                    // a bad index gives one result, black reads too
                    queue_result(8'h00, 1'b1, 1'b1);
                end else if (r.kind == tpefb_pkg::REQ_RD_BLACK) begin
                    v = shadow_black[r.index];
                    queue_result(spread_nibble(v[7:4]), 1'b0, 1'b0);
                    queue_result(spread_nibble(v[3:0]), 1'b1, 1'b0);
                end else begin
                    queue_result(shadow_red[r.index], 1'b1, 1'b0);
                end
            end
        endcase
    endfunction

    // typed-in rows give known_cnt; zero means the predictor decides
    function automatic void add_row(input tpefb_pkg::t_req_type kind, input int x, input int y,
                                    input int color, input int pat, input int nbits,
                                    input int idx, input int known_cnt = 0,
                                    input int d0 = 0, input int d1 = 0, input int err = 0);
        t_fb_request r;
        r.kind      = kind;
        r.pos_x     = 8'(x);
        r.pos_y     = 8'(y);
        r.color     = 2'(color);
        r.pattern   = 8'(pat);
        r.nbits     = 4'(nbits);
        r.index     = 13'(idx);
        r.known_cnt = known_cnt;
        r.known_d0  = 8'(d0);
        r.known_d1  = 8'(d1);
        r.known_err = (err != 0);
        directed_rows.push_back(r);
    endfunction

    // present one request, with random idle cycles ahead of it, until transferred
    task automatic send_request(input t_fb_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        offered_q.push_back(r);
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= r.kind;
        req_bus.pos_x       <= r.pos_x;
        req_bus.pos_y       <= r.pos_y;
        req_bus.pixel_color <= r.color;
        req_bus.pattern     <= r.pattern;
        req_bus.valid_bits  <= r.nbits;
        req_bus.byte_index  <= r.index;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
    endtask

    // response side back-pressure, redrawn every cycle
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // transfer monitor: predict on each request, check on each result
    always @(posedge i_clk) begin : transfer_monitor
        t_fb_request taken;
        t_fb_result  want;
        if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            taken = offered_q.pop_front();
            predict_request(taken);
            if (taken.known_cnt != 0) begin
                // typed rows replace what the predictor just queued
                repeat (taken.known_cnt == 2 ? 2 : 1) void'(expected_results.pop_back());
                if (taken.known_cnt == 2) begin
                    queue_result(taken.known_d0, 1'b0, 1'b0);
                    queue_result(taken.known_d1, 1'b1, 1'b0);
                end else begin
                    queue_result(taken.known_d0, 1'b1, taken.known_err);
                end
            end
        end
        if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: data_byte %02h is_last %0b range_error %0b",
                       rsp_bus.data_byte, rsp_bus.is_last, rsp_bus.range_error);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (rsp_bus.data_byte !== want.data_byte) begin
                    $error("data_byte: expected %02h, got %02h", want.data_byte,
                           rsp_bus.data_byte);
                    fail_count++;
                end
                if (rsp_bus.is_last !== want.is_last) begin
                    $error("is_last: expected %0b, got %0b", want.is_last, rsp_bus.is_last);
                    fail_count++;
                end
                if (rsp_bus.range_error !== want.range_error) begin
                    $error("range_error: expected %0b, got %0b", want.range_error,
                           rsp_bus.range_error);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_fb_request r;
        int          roll;
        int          pick;
        int          phase_send  [4] = '{0, 64, 0, 18};
        int          phase_stall [4] = '{0, 0, 64, 18};

        for (int i = 0; i < tpefb_pkg::BUF_LEN; i++) begin
            shadow_black[i] = 8'hFF;
            shadow_red[i]   = 8'hFF;
        end

        req_bus.valid       <= 1'b0;
        req_bus.req_type    <= tpefb_pkg::REQ_PIXEL;
        req_bus.pos_x       <= '0;
        req_bus.pos_y       <= '0;
        req_bus.pixel_color <= '0;
        req_bus.pattern     <= '0;
        req_bus.valid_bits  <= '0;
        req_bus.byte_index  <= '0;
        i_rst_n             <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // freshly cleared planes read back white
        add_row(tpefb_pkg::REQ_RD_BLACK, 0, 0, 0, 0, 0, 0, 2, 8'hFF, 8'hFF);
        add_row(tpefb_pkg::REQ_RD_RED,   0, 0, 0, 0, 0, 0, 1, 8'hFF);
        add_row(tpefb_pkg::REQ_RD_BLACK, 0, 0, 0, 0, 0, tpefb_pkg::BUF_LEN - 1, 2,
                8'hFF, 8'hFF);
        // read index past the plane, one error result even for black
        add_row(tpefb_pkg::REQ_RD_RED,   0, 0, 0, 0, 0, tpefb_pkg::BUF_LEN, 1, 0, 0, 1);
        add_row(tpefb_pkg::REQ_RD_BLACK, 0, 0, 0, 0, 0, 8191, 1, 0, 0, 1);
        // pixel coordinates off the panel
        add_row(tpefb_pkg::REQ_PIXEL, tpefb_pkg::PIXEL_WIDTH, 0, tpefb_pkg::COLOR_BLACK,
                0, 0, 0, 1, 0, 0, 1);
        add_row(tpefb_pkg::REQ_PIXEL, 0, tpefb_pkg::PIXEL_HEIGHT, tpefb_pkg::COLOR_RED,
                0, 0, 0, 1, 0, 0, 1);
        add_row(tpefb_pkg::REQ_PIXEL, 255, 255, 3, 0, 0, 0, 1, 0, 0, 1);
        // corners and both inks
        add_row(tpefb_pkg::REQ_PIXEL, 0, 0, tpefb_pkg::COLOR_BLACK, 0, 0, 0);
        add_row(tpefb_pkg::REQ_PIXEL, 7, 0, tpefb_pkg::COLOR_RED, 0, 0, 0);
        add_row(tpefb_pkg::REQ_PIXEL, tpefb_pkg::PIXEL_WIDTH - 1, tpefb_pkg::PIXEL_HEIGHT - 1,
                tpefb_pkg::COLOR_BLACK, 0, 0, 0);
        add_row(tpefb_pkg::REQ_RD_BLACK, 0, 0, 0, 0, 0, 0);
        add_row(tpefb_pkg::REQ_RD_RED,   0, 0, 0, 0, 0, 0);
        add_row(tpefb_pkg::REQ_RD_BLACK, 0, 0, 0, 0, 0, tpefb_pkg::BUF_LEN - 1);
        // bitmap bytes: straddling two plane bytes, empty, saturated count
        add_row(tpefb_pkg::REQ_BITMAP, 12, 1, tpefb_pkg::COLOR_RED, 8'hA5, 8, 0);
        add_row(tpefb_pkg::REQ_BITMAP, 16, 1, tpefb_pkg::COLOR_BLACK, 8'hFF, 0, 0);
        add_row(tpefb_pkg::REQ_BITMAP, tpefb_pkg::PIXEL_WIDTH - 8, 2, tpefb_pkg::COLOR_BLACK,
                8'hFF, 15, 0);
        // bitmap spans past the right edge or below the last row
        add_row(tpefb_pkg::REQ_BITMAP, tpefb_pkg::PIXEL_WIDTH - 7, 2, tpefb_pkg::COLOR_BLACK,
                8'h00, 8, 0, 1, 0, 0, 1);
        add_row(tpefb_pkg::REQ_BITMAP, 0, tpefb_pkg::PIXEL_HEIGHT, tpefb_pkg::COLOR_RED,
                8'hFF, 1, 0, 1, 0, 0, 1);
        add_row(tpefb_pkg::REQ_BITMAP, 255, 0, tpefb_pkg::COLOR_BLACK, 8'hFF, 0, 0,
                1, 0, 0, 1);
        // color three and white both erase
        add_row(tpefb_pkg::REQ_PIXEL, 0, 0, 3, 0, 0, 0);
        add_row(tpefb_pkg::REQ_PIXEL, 7, 0, 0, 0, 0, 0);
        add_row(tpefb_pkg::REQ_RD_RED,   0, 0, 0, 0, 0, tpefb_pkg::BYTE_WIDTH + 1);
        add_row(tpefb_pkg::REQ_RD_BLACK, 0, 0, 0, 0, 0,
                2 * tpefb_pkg::BYTE_WIDTH + tpefb_pkg::BYTE_WIDTH - 1);
        add_row(tpefb_pkg::REQ_RD_BLACK, 0, 0, 0, 0, 0, 0);

        foreach (directed_rows[i]) send_request(directed_rows[i]);

        // random traffic: mostly in-range writes and read-backs of bytes just drawn
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = phase_send[phase];
            recv_stall_pct = phase_stall[phase];
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                roll        = $urandom_range(99);
                r.pos_x     = 8'($urandom);
                r.pos_y     = 8'($urandom);
                r.color     = 2'($urandom);
                r.pattern   = 8'($urandom);
                r.nbits     = 4'($urandom);
                r.index     = 13'($urandom);
                r.known_cnt = 0;
                if (roll < 30) begin
                    r.kind = tpefb_pkg::REQ_PIXEL;
                    if ($urandom_range(9) != 0) begin
                        r.pos_x = 8'($urandom_range(tpefb_pkg::PIXEL_WIDTH - 1));
                        r.pos_y = 8'($urandom_range(tpefb_pkg::PIXEL_HEIGHT - 1));
                    end
                end else if (roll < 55) begin
                    r.kind = tpefb_pkg::REQ_BITMAP;
                    if ($urandom_range(9) != 0) begin
                        r.pos_x = 8'($urandom_range(tpefb_pkg::PIXEL_WIDTH - 1));
                        r.pos_y = 8'($urandom_range(tpefb_pkg::PIXEL_HEIGHT - 1));
                        r.nbits = 4'($urandom_range(8));
                    end
                end else begin
                    r.kind = (roll < 80) ? tpefb_pkg::REQ_RD_BLACK : tpefb_pkg::REQ_RD_RED;
                    pick   = $urandom_range(9);
                    if (pick < 7 && recent_bytes.size() != 0) begin
                        r.index = 13'(recent_bytes[$urandom_range(recent_bytes.size() - 1)]);
                    end else if (pick < 9) begin
                        r.index = 13'($urandom_range(tpefb_pkg::BUF_LEN - 1));
                    end
                end
                if (r.kind inside {tpefb_pkg::REQ_PIXEL, tpefb_pkg::REQ_BITMAP} &&
                    r.pos_x < tpefb_pkg::PIXEL_WIDTH && r.pos_y < tpefb_pkg::PIXEL_HEIGHT) begin
                    recent_bytes.push_back(int'(r.pos_y) * tpefb_pkg::BYTE_WIDTH +
                                           int'(r.pos_x) / 8);
                    if (recent_bytes.size() > 48) void'(recent_bytes.pop_front());
                end
                send_request(r);
            end
        end
        req_bus.valid <= 1'b0;
        // let the monitor book the last transfer before counting what is owed
        @(posedge i_clk);

        // drain, then a short quiet spell to catch stray results
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
